[rtl/cac_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cac_pkg
// Types, register indexes and helpers shared by the set-associative cache
// tag model.
// ----------------------------------------------------------------------------
package cac_pkg;

    localparam int IN_ADDR_W  = 48;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [5:0] OFFSET_RST = 6'd6;
    localparam logic [3:0] INDEX_RST  = 4'd0;
    localparam logic [4:0] WAYS_RST   = 5'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_BITS,
        CFG_INDEX_BITS,
        CFG_WAYS_IN_USE,
        CFG_INDEX_MODE
    } t_cfg_reg;

    typedef struct packed {
        logic [IN_ADDR_W-1:0] address;
        logic                 is_write;
    } t_in;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] mem_reads;
        logic [CNT_W-1:0] mem_writes;
        logic [CNT_W-1:0] hit_count;
        logic [CNT_W-1:0] miss_count;
    } t_out;

    typedef struct packed {
        logic [5:0] offset_bits;
        logic [3:0] index_bits;
        logic [4:0] ways_in_use;
        logic       index_mode;
    } t_cfg;

    // Controller to datapath.
    typedef struct packed {
        logic clear;
        logic load;
        logic decode;
        logic reduce;
        logic update;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic clear_last;
        logic head_ok;
    } t_stat;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

[rtl/cac_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cac_ctrl
// Sequencer for the cache tag model: clearing pass, then one lookup at a time.
// ----------------------------------------------------------------------------
module cac_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  cac_pkg::t_stat i_stat,
    output cac_pkg::t_cmd  o_cmd
);
    import cac_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_LATCH,
        S_REDUCE,
        S_UPDATE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.load = start;
                if (start) n_state = S_DECODE;
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = S_LATCH;
            end
            S_LATCH: begin
                n_state = S_REDUCE;
            end
            S_REDUCE: begin
                // The stored head may be out of range after a change of ways.
                o_cmd.reduce = 1'b1;
                if (i_stat.head_ok) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign busy = r_busy;

endmodule

[rtl/cac_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cac_dp
// Datapath: address split, set memories, way compare, FIFO victim and counters.
// ----------------------------------------------------------------------------
module cac_dp #(
    parameter int ADDR_BITS = 48,
    parameter int MAX_SETS  = 1024,
    parameter int MAX_WAYS  = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cac_pkg::t_cfg  i_cfg,
    input  cac_pkg::t_in   i_item,
    input  cac_pkg::t_cmd  i_cmd,
    output cac_pkg::t_stat o_stat,
    output cac_pkg::t_out  o_result,
    output logic           o_done
);
    import cac_pkg::*;

    localparam int AW    = ADDR_BITS;
    localparam int SW    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int LIM   = $clog2(MAX_SETS + 1) - 1;
    localparam int WW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int FW    = $clog2(MAX_WAYS + 1);
    localparam int SHW   = ($clog2(AW + 1) > 6) ? $clog2(AW + 1) : 6;
    localparam int EW    = (FW > 5) ? FW : 5;

    // Effective configuration.
    logic [SHW-1:0] ob, ib, ib_a, room, tb;
    logic [EW-1:0]  ways_x, eways_x;
    logic [FW-1:0]  eways;

    always_comb begin
        ob   = (SHW'(i_cfg.offset_bits) > SHW'(AW)) ? SHW'(AW) : SHW'(i_cfg.offset_bits);
        ib_a = (SHW'(i_cfg.index_bits) > SHW'(LIM)) ? SHW'(LIM) : SHW'(i_cfg.index_bits);
        room = SHW'(AW) - ob;
        ib   = (ib_a > room) ? room : ib_a;
        tb   = room - ib;
        ways_x  = EW'(i_cfg.ways_in_use);
        eways_x = (ways_x == '0) ? EW'(1)
                : ((ways_x > EW'(MAX_WAYS)) ? EW'(MAX_WAYS) : ways_x);
        eways   = FW'(eways_x);
    end

    // Captured access.
    logic [AW+IN_ADDR_W-1:0] addr_ext;
    logic [AW-1:0]           r_addr;
    logic                    r_wr;

    assign addr_ext = {{AW{1'b0}}, i_item.address};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= addr_ext[AW-1:0];
            r_wr   <= i_item.is_write;
        end
    end

    // Set and tag split.
    logic [AW-1:0] shifted, set_full, n_tag;
    logic [SW-1:0] n_set;

    always_comb begin
        shifted = r_addr >> ob;
        if (!i_cfg.index_mode) begin
            set_full = shifted & ~({AW{1'b1}} << ib);
            n_tag    = shifted >> ib;
        end else begin
            set_full = (ib == '0) ? '0 : (r_addr >> (SHW'(AW) - ib));
            n_tag    = shifted & ~({AW{1'b1}} << tb);
        end
        n_set = SW'(set_full);
    end

    logic [AW-1:0] r_tag;
    logic [SW-1:0] r_set;

    always_ff @(posedge i_clk) begin
        if (i_cmd.decode) begin
            r_tag <= n_tag;
            r_set <= n_set;
        end
    end

    // Set memories: one row holds all ways of a set.
    logic [AW*MAX_WAYS-1:0] m_tag   [MAX_SETS];
    logic [MAX_WAYS-1:0]    m_valid [MAX_SETS];
    logic [FW-1:0]          m_fill  [MAX_SETS];
    logic [WW-1:0]          m_head  [MAX_SETS];

    logic [AW*MAX_WAYS-1:0] r_rd_tag;
    logic [MAX_WAYS-1:0]    r_rd_valid;
    logic [FW-1:0]          r_rd_fill;
    logic [WW-1:0]          r_rd_head;

    always_ff @(posedge i_clk) begin
        if (i_cmd.decode) begin
            r_rd_tag   <= m_tag[n_set];
            r_rd_valid <= m_valid[n_set];
            r_rd_fill  <= m_fill[n_set];
            r_rd_head  <= m_head[n_set];
        end
    end

    // Clearing pass index.
    logic [SW-1:0] r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clear) begin
            r_clr_idx <= r_clr_idx + SW'(1);
        end
    end

    // Head reduction by repeated subtraction of the way count.
    logic [WW-1:0] r_head;
    logic          head_ok;

    assign head_ok = (FW'(r_head) < eways);

    always_ff @(posedge i_clk) begin
        if (i_cmd.decode) begin
            r_head <= '0;
        end else if (i_cmd.reduce) begin
            if (r_head == '0 && !head_ok) begin
                r_head <= '0;
            end else if (!head_ok) begin
                r_head <= r_head - WW'(eways);
            end
        end else if (!i_cmd.update && !i_cmd.clear && !i_cmd.load) begin
            r_head <= r_rd_head;
        end
    end

    assign o_stat.clear_last = (r_clr_idx == SW'(MAX_SETS - 1));
    assign o_stat.head_ok    = head_ok;

    // Lookup and victim selection.
    logic                   hit, full;
    logic [WW-1:0]          slot;
    logic [FW-1:0]          head_inc, new_fill;
    logic [WW-1:0]          new_head;
    logic [MAX_WAYS-1:0]    new_valid;
    logic [AW*MAX_WAYS-1:0] new_row;

    always_comb begin
        hit = 1'b0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if ((FW'(w) < eways) && r_rd_valid[w] && (r_rd_tag[w*AW +: AW] == r_tag)) begin
                hit = 1'b1;
            end
        end
        full     = (r_rd_fill >= eways);
        slot     = full ? r_head : WW'(r_rd_fill);
        head_inc = FW'(r_head) + FW'(1);
        new_fill = full ? r_rd_fill : r_rd_fill + FW'(1);
        new_head = (head_inc == eways) ? '0 : WW'(head_inc);
        if (!full) new_head = r_rd_head;
        new_valid = r_rd_valid;
        new_row   = r_rd_tag;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WW'(w) == slot) begin
                new_valid[w]        = 1'b1;
                new_row[w*AW +: AW] = r_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            m_valid[r_clr_idx] <= '0;
            m_fill[r_clr_idx]  <= '0;
            m_head[r_clr_idx]  <= '0;
        end else if (i_cmd.update && !hit) begin
            m_tag[r_set]   <= new_row;
            m_valid[r_set] <= new_valid;
            m_fill[r_set]  <= new_fill;
            m_head[r_set]  <= new_head;
        end
    end

    // Counters and result register.
    logic [CNT_W-1:0] r_reads, r_writes, r_hits, r_misses;
    logic [CNT_W-1:0] n_reads, n_writes, n_hits, n_misses;
    logic             r_done;
    t_out             r_out;

    always_comb begin
        n_reads  = hit ? r_reads : sat_inc(r_reads);
        n_misses = hit ? r_misses : sat_inc(r_misses);
        n_hits   = hit ? sat_inc(r_hits) : r_hits;
        n_writes = r_wr ? sat_inc(r_writes) : r_writes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reads  <= '0;
            r_writes <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            r_done   <= 1'b0;
        end else begin
            r_done <= i_cmd.update;
            if (i_cmd.update) begin
                r_reads  <= n_reads;
                r_writes <= n_writes;
                r_hits   <= n_hits;
                r_misses <= n_misses;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_out.hit        <= hit;
            r_out.mem_reads  <= n_reads;
            r_out.mem_writes <= n_writes;
            r_out.hit_count  <= n_hits;
            r_out.miss_count <= n_misses;
        end
    end

    assign o_result = r_out;
    assign o_done   = r_done;

endmodule

[rtl/set_assoc_cache_fifo_model.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_model
// Set-associative tag store with FIFO replacement and access counters.
// ----------------------------------------------------------------------------
// Usage: present an access on i_item and raise start; it is taken on a rising
// edge where start is high and busy is low. Each access gives one result on
// o_result, valid for exactly one cycle while o_done is high; the receiver
// cannot stall it and must take it in that cycle.
// Sequence: o_done is registered from the update step and rises at the edge
// that ends it; a FIFO head left out of range by a change of ways_in_use makes
// the head check repeat, subtracting the way count each time, before the update. The
// path runs capture, address split with set read, row latch, head check, then
// a single read-modify-write of the set row, so one access is in flight at a
// time. Busy falls at the same edge that raises o_done, so the next access can
// be taken at the edge that ends the result cycle.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at once;
// the user must write only while busy is low; the block does not enforce it.
// Reset: counters and configuration registers return to their defaults, and
// a clearing pass over all MAX_SETS sets wipes the valid bits, fill counts
// and FIFO heads; busy is high during the pass and no access is taken.
// ----------------------------------------------------------------------------
module set_assoc_cache_fifo_model #(
    parameter int ADDR_BITS = 48,
    parameter int MAX_SETS  = 1024,
    parameter int MAX_WAYS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  cac_pkg::t_in                       i_item,
    output cac_pkg::t_out                      o_result,
    output logic                               o_done,
    input  logic                               i_cfg_we,
    input  logic [cac_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cac_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import cac_pkg::*;

    t_cfg  r_cfg;
    t_cmd  cmd;
    t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_bits <= OFFSET_RST;
            r_cfg.index_bits  <= INDEX_RST;
            r_cfg.ways_in_use <= WAYS_RST;
            r_cfg.index_mode  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_OFFSET_BITS: r_cfg.offset_bits <= i_cfg_data[5:0];
                CFG_INDEX_BITS:  r_cfg.index_bits  <= i_cfg_data[3:0];
                CFG_WAYS_IN_USE: r_cfg.ways_in_use <= i_cfg_data[4:0];
                CFG_INDEX_MODE:  r_cfg.index_mode  <= i_cfg_data[0];
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    cac_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    cac_dp #(
        .ADDR_BITS (ADDR_BITS),
        .MAX_SETS  (MAX_SETS),
        .MAX_WAYS  (MAX_WAYS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result),
        .o_done   (o_done)
    );

endmodule
